[design/escaped_api_frame_encoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - assertion macros
// Shared concurrent assertion forms used by the encoder top level.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_API_FRAME_ENCODER_UNIT_DEFINES_SVH
`define ESCAPED_API_FRAME_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define EAFE_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EAFE_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/eafe_pkg.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - package
// Types, register codes and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package eafe_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_BYTE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_BYTE    = 3'd4;

  localparam logic [15:0] RST_FRAME_LENGTH = 16'h0010;
  localparam logic [7:0]  RST_START_BYTE   = 8'h7E;
  localparam logic [7:0]  RST_ESCAPE_BYTE  = 8'h7D;
  localparam logic [7:0]  RST_XON_BYTE     = 8'h11;
  localparam logic [7:0]  RST_XOFF_BYTE    = 8'h13;

  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_BASE = 8'hFF;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  start_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  xon_byte;
    logic [7:0]  xoff_byte;
  } cfg_t;

  // one classified data byte, ready for the output sequencer
  typedef struct packed {
    logic [7:0] data;
    logic       first;  // header goes before this byte
    logic       last;   // checksum goes after this byte
    logic [7:0] csum;
  } job_t;

  typedef struct packed {
    logic count_zero;
    logic frame_end;
  } front_stat_t;

  typedef struct packed {
    logic esc_pending;
    logic job_active;
  } back_stat_t;

endpackage

[design/eafe_fifo.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - job queue
// Small flip-flop queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module eafe_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  eafe_pkg::job_t    wdata_i,
  input  logic              pop_i,
  output eafe_pkg::job_t    rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  eafe_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d;
  logic [PW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q,  cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[design/eafe_front.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - front end
// Tracks frame position and running sum, tags each data byte with header and
// checksum needs, and precomputes the checksum byte.
// ----------------------------------------------------------------------------
module eafe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic [15:0]           frame_length_i,
  output eafe_pkg::job_t        job_o,
  output eafe_pkg::front_stat_t stat_o
);

  logic [15:0] count_q, count_d;
  logic [7:0]  sum_q,   sum_d;
  logic        first;
  logic        frame_end;
  logic [7:0]  new_sum;
  logic [16:0] next_cnt;

  assign first    = (count_q == '0);
  assign new_sum  = (first ? 8'h00 : sum_q) + data_byte_i;
  assign next_cnt = {1'b0, count_q} + 17'd1;

  // a zero length register means a 65536-byte frame
  assign frame_end = (frame_length_i == '0) ? (count_q == 16'hFFFF)
                                            : (next_cnt >= {1'b0, frame_length_i});

  assign job_o.data  = data_byte_i;
  assign job_o.first = first;
  assign job_o.last  = frame_end;
  assign job_o.csum  = eafe_pkg::SUM_BASE - new_sum;

  assign stat_o.count_zero = first;
  assign stat_o.frame_end  = frame_end;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept_i) begin
      count_d = frame_end ? '0 : next_cnt[15:0];
      sum_d   = frame_end ? '0 : new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule

[design/eafe_back.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - back end
// Byte sequencer: walks header, data and checksum of the head job, inserts
// escape bytes, and holds the result in an output register.
// ----------------------------------------------------------------------------
module eafe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  eafe_pkg::cfg_t       cfg_i,
  input  eafe_pkg::job_t       job_i,
  input  logic                 job_empty_i,
  output logic                 job_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           out_byte_o,
  output logic                 run_last_o,
  output logic                 frame_end_o,
  output eafe_pkg::back_stat_t stat_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CSUM
  } phase_e;

  phase_e     ph_q, ph_d, cur_ph;
  logic       esc_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q;
  logic       frame_end_q;

  logic [7:0] cur_byte;
  logic [7:0] emit_byte;
  logic       special;
  logic       advance;
  logic       done_byte;
  logic       final_byte;

  // idle means the head job has not started yet
  assign cur_ph = (ph_q != PH_IDLE) ? ph_q : (job_i.first ? PH_START : PH_DATA);

  always_comb begin
    case (cur_ph)
      PH_START:  cur_byte = cfg_i.start_byte;
      PH_LEN_HI: cur_byte = cfg_i.frame_length[15:8];
      PH_LEN_LO: cur_byte = cfg_i.frame_length[7:0];
      PH_CSUM:   cur_byte = job_i.csum;
      default:   cur_byte = job_i.data;
    endcase
  end

  // the start delimiter is always sent raw
  assign special = (cur_ph != PH_START) &&
                   ((cur_byte == cfg_i.start_byte) || (cur_byte == cfg_i.escape_byte) ||
                    (cur_byte == cfg_i.xon_byte)   || (cur_byte == cfg_i.xoff_byte));

  assign advance    = !job_empty_i && (!out_valid_q || pop_i);
  assign done_byte  = esc_q || !special;
  assign final_byte = done_byte &&
                      ((cur_ph == PH_CSUM) || ((cur_ph == PH_DATA) && !job_i.last));
  assign job_pop_o  = advance && final_byte;

  always_comb begin
    if (esc_q) begin
      emit_byte = cur_byte ^ eafe_pkg::ESC_XOR;
    end else if (special) begin
      emit_byte = cfg_i.escape_byte;
    end else begin
      emit_byte = cur_byte;
    end
  end

  always_comb begin
    ph_d = cur_ph;
    if (done_byte) begin
      case (cur_ph)
        PH_START:  ph_d = PH_LEN_HI;
        PH_LEN_HI: ph_d = PH_LEN_LO;
        PH_LEN_LO: ph_d = PH_DATA;
        PH_DATA:   ph_d = job_i.last ? PH_CSUM : PH_IDLE;
        default:   ph_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      run_last_q  <= 1'b0;
      frame_end_q <= 1'b0;
    end else if (advance) begin
      ph_q        <= ph_d;
      esc_q       <= !done_byte;
      out_valid_q <= 1'b1;
      out_byte_q  <= emit_byte;
      run_last_q  <= final_byte;
      frame_end_q <= done_byte && (cur_ph == PH_CSUM);
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

  assign stat_o.esc_pending = esc_q;
  assign stat_o.job_active  = (ph_q != PH_IDLE);

endmodule

[design/escaped_api_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder
// Turns frame data bytes into an escaped serial API frame with start
// delimiter, 16-bit length field and 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Each data byte yields one to nine output bytes, delivered one per clock
// while pop is held and a job is queued: one for a plain data byte, two
// when it is escaped, plus the start delimiter and two (possibly escaped)
// length bytes ahead of the first byte of a frame and one or two checksum
// bytes after the last. The output byte sequencer sets the rate and works
// on one queued item at a time. The input side takes a byte per cycle
// while the QUEUE_DEPTH-entry job queue has room, so input and output
// stall independently. Configuration is accepted every cycle.
module escaped_api_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte_o,
  output logic                           run_last_o,
  output logic                           frame_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [eafe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [eafe_pkg::CFG_DATA_W-1:0] cfg_data_i
);

`include "escaped_api_frame_encoder_unit_defines.svh"

  eafe_pkg::cfg_t        cfg_q;
  eafe_pkg::job_t        fr_job;
  eafe_pkg::job_t        q_job;
  eafe_pkg::front_stat_t fr_stat;
  eafe_pkg::back_stat_t  bk_stat;
  logic                  accept;
  logic                  q_pop;
  logic                  q_empty;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length <= eafe_pkg::RST_FRAME_LENGTH;
      cfg_q.start_byte   <= eafe_pkg::RST_START_BYTE;
      cfg_q.escape_byte  <= eafe_pkg::RST_ESCAPE_BYTE;
      cfg_q.xon_byte     <= eafe_pkg::RST_XON_BYTE;
      cfg_q.xoff_byte    <= eafe_pkg::RST_XOFF_BYTE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        eafe_pkg::CFG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data_i;
        eafe_pkg::CFG_START_BYTE:   cfg_q.start_byte   <= cfg_data_i[7:0];
        eafe_pkg::CFG_ESCAPE_BYTE:  cfg_q.escape_byte  <= cfg_data_i[7:0];
        eafe_pkg::CFG_XON_BYTE:     cfg_q.xon_byte     <= cfg_data_i[7:0];
        eafe_pkg::CFG_XOFF_BYTE:    cfg_q.xoff_byte    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  eafe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .frame_length_i (cfg_q.frame_length),
    .job_o          (fr_job),
    .stat_o         (fr_stat)
  );

  eafe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (fr_job),
    .pop_i   (q_pop),
    .rdata_o (q_job),
    .full_o  (full),
    .empty_o (q_empty)
  );

  eafe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .stat_o      (bk_stat)
  );

  `EAFE_ASSERT_NOW(a_fend_is_last, clk_i, rst_ni, !empty && frame_end_o, run_last_o, "frame end byte not marked last of its request")
  `EAFE_ASSERT_NOW(a_seq_has_job, clk_i, rst_ni, bk_stat.esc_pending || bk_stat.job_active, !q_empty, "sequencer mid-request with empty job queue")
  `EAFE_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, accept && fr_stat.frame_end, fr_stat.count_zero, "frame count not cleared after frame end")

endmodule

[verif/escaped_api_frame_encoder_unit_test.sv]
// ----------------------------------------------------------------------------
// Escaped API frame encoder - block-level test
// Data bytes go in through the push/full side and escaped frame bytes come
// out through the empty/pop side. Each received byte is checked against an
// in-bench frame encoder. Configuration writes happen only when the block
// has drained, and some of them fall mid-frame. The run covers three idle
// mixes, each opened by a long receiver stall that backs up the input side.
// ----------------------------------------------------------------------------
module escaped_api_frame_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import eafe_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAUSE = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 300;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } serial_byte_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [7:0]            data_byte_i = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  run_last_o;
  logic                  frame_end_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic [7:0]   data_bytes_q[$];    // bytes waiting to be offered
  serial_byte_t serial_bytes_q[$];  // escaped bytes still owed by the block

  // encoder copy: settings and frame progress
  cfg_t        enc_cfg;
  logic [15:0] frame_pos;
  logic [7:0]  frame_sum;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int err_cnt       = 0;
  int cycle_cnt     = 0;

  escaped_api_frame_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void add_serial_byte(logic [7:0] b, logic fend);
    serial_bytes_q.push_back('{out_byte: b, run_last: 1'b0, frame_end: fend});
  endfunction

  function automatic void add_escaped_byte(logic [7:0] b, logic fend);
    if (b == enc_cfg.start_byte || b == enc_cfg.escape_byte ||
        b == enc_cfg.xon_byte || b == enc_cfg.xoff_byte) begin
      add_serial_byte(enc_cfg.escape_byte, 1'b0);
      add_serial_byte(b ^ ESC_XOR, fend);
    end else begin
      add_serial_byte(b, fend);
    end
  endfunction

  // bytes the block owes for one accepted data byte
  function automatic void encode_data_byte(logic [7:0] data);
    logic [16:0]  frame_limit;
    logic [16:0]  next_pos;
    serial_byte_t tail;
    frame_limit = (enc_cfg.frame_length == '0) ? 17'h10000 : {1'b0, enc_cfg.frame_length};
    if (frame_pos == '0) begin
      add_serial_byte(enc_cfg.start_byte, 1'b0);
      add_escaped_byte(enc_cfg.frame_length[15:8], 1'b0);
      add_escaped_byte(enc_cfg.frame_length[7:0], 1'b0);
      frame_sum = '0;
    end
    add_escaped_byte(data, 1'b0);
    frame_sum = frame_sum + data;
    next_pos = {1'b0, frame_pos} + 17'd1;
    // a shortened length may already be passed: close the frame right here
    if (next_pos >= frame_limit) begin
      add_escaped_byte(SUM_BASE - frame_sum, 1'b1);
      frame_pos = '0;
      frame_sum = '0;
    end else begin
      frame_pos = next_pos[15:0];
    end
    tail = serial_bytes_q.pop_back();
    tail.run_last = 1'b1;
    serial_bytes_q.push_back(tail);
  endfunction

  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(5))
      0:       return enc_cfg.start_byte;
      1:       return enc_cfg.escape_byte;
      2:       return enc_cfg.xon_byte;
      3:       return enc_cfg.xoff_byte;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_data_byte(data_byte_i);
      end
      if (!push || !full) begin
        if (data_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push        <= 1'b1;
          data_byte_i <= data_bytes_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    serial_byte_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (serial_bytes_q.size() == 0) begin
          $display("%0t: unexpected output, expected none actual %02h run_last %0b frame_end %0b",
                   $time, out_byte_o, run_last_o, frame_end_o);
          err_cnt++;
        end else begin
          want = serial_bytes_q.pop_front();
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("run_last", want.run_last, run_last_o);
          check_field("frame_end", want.frame_end, frame_end_o);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (data_bytes_q.size() != 0 || push || serial_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_cfg_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_LENGTH: enc_cfg.frame_length = val;
      CFG_START_BYTE:   enc_cfg.start_byte   = val[7:0];
      CFG_ESCAPE_BYTE:  enc_cfg.escape_byte  = val[7:0];
      CFG_XON_BYTE:     enc_cfg.xon_byte     = val[7:0];
      CFG_XOFF_BYTE:    enc_cfg.xoff_byte    = val[7:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [7:0]  first_frame[16] = '{8'h00, 8'hFF, 8'h7E, 8'h7D, 8'h11, 8'h13, 8'h5E, 8'h5D,
                                     8'h31, 8'h33, 8'h20, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55};
    logic [15:0] len;
    logic [7:0]  special;
    int          items;
    int          seg_len;
    int          r;

    enc_cfg = '{frame_length: RST_FRAME_LENGTH, start_byte: RST_START_BYTE,
                escape_byte: RST_ESCAPE_BYTE, xon_byte: RST_XON_BYTE,
                xoff_byte: RST_XOFF_BYTE};
    frame_pos = '0;
    frame_sum = '0;
    send_idle_pct = 26;
    recv_idle_pct = 78;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one full frame at reset settings, each default special value in the data
    foreach (first_frame[i]) data_bytes_q.push_back(first_frame[i]);
    wait_drained();

    // single-byte frames
    write_cfg_reg(CFG_FRAME_LENGTH, 16'd1);
    data_bytes_q.push_back(8'h7E);
    data_bytes_q.push_back(8'h00);
    wait_drained();

    // largest nonzero length value, all special values overlapping
    write_cfg_reg(CFG_FRAME_LENGTH, 16'hFFFF);
    write_cfg_reg(CFG_START_BYTE, 16'hA5FF);
    write_cfg_reg(CFG_ESCAPE_BYTE, 16'h5A00);
    write_cfg_reg(CFG_XON_BYTE, 16'h00FF);
    write_cfg_reg(CFG_XOFF_BYTE, 16'hFFFF);
    data_bytes_q.push_back(8'h00);
    data_bytes_q.push_back(8'hFF);
    wait_drained();

    // escape set and length swapped mid-frame, zero length runs on
    write_cfg_reg(CFG_START_BYTE, 16'h007E);
    write_cfg_reg(CFG_ESCAPE_BYTE, 16'h007D);
    write_cfg_reg(CFG_XON_BYTE, 16'h0011);
    write_cfg_reg(CFG_XOFF_BYTE, 16'h0013);
    write_cfg_reg(CFG_FRAME_LENGTH, 16'd0);
    data_bytes_q.push_back(8'h7D);
    wait_drained();

    // count already past the new length: frame closes on the next byte
    write_cfg_reg(CFG_FRAME_LENGTH, 16'd2);
    data_bytes_q.push_back(8'h5A);
    wait_drained();

    // zero length header, then length cut to exactly the count reached
    write_cfg_reg(CFG_FRAME_LENGTH, 16'd0);
    data_bytes_q.push_back(8'h13);
    data_bytes_q.push_back(8'h00);
    wait_drained();
    write_cfg_reg(CFG_FRAME_LENGTH, 16'd3);
    data_bytes_q.push_back(8'hFF);
    wait_drained();

    // unused register index must leave everything alone
    write_cfg_reg(CFG_XOFF_BYTE + 3'd3, 16'hFFFF);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 26 : 0;
      items = 0;
      while (items < RAND_ITEMS / 3) begin
        if ($urandom_range(9) < 7) begin
          r = $urandom_range(9);
          if (r == 0)      len = 16'hFFFF;
          else if (r == 1) len = 16'h0000;
          else if (r < 6)  len = 16'($urandom_range(1, 6));
          else             len = 16'($urandom_range(7, 40));
          write_cfg_reg(CFG_FRAME_LENGTH, len);
        end
        for (int k = CFG_START_BYTE; k <= CFG_XOFF_BYTE; k++) begin
          if ($urandom_range(1) == 1) begin
            if ($urandom_range(3) == 0) special = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            else                        special = 8'($urandom);
            write_cfg_reg(CFG_IDX_W'(k), {8'($urandom), special});
          end
        end
        // long receiver stall at the start of each mode, input keeps coming
        if (items == 0) hold_reqs++;
        seg_len = $urandom_range(8, 40);
        repeat (seg_len) data_bytes_q.push_back(pick_data_byte());
        items += seg_len;
        wait_drained();
      end
    end

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
